// ===== rtl/hhc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the humidity controller.
package hhc_pkg;

   // Tick counter width (elapsed counters saturate at all ones).
   localparam int CntBits    = 16;
   localparam int PeriodBits = 16;
   localparam int CmpBits    = (CntBits > PeriodBits) ? CntBits : PeriodBits;

   localparam int SpBits     = 7;
   localparam int StepBits   = 5;
   localparam int HystBits   = 9;
   localparam int HumBits    = 10;
   localparam int BoundBits  = 11;
   localparam int CalcBits   = 12;   // signed setpoint*10 +/- hysteresis
   localparam int SumBits    = 9;    // signed setpoint +/- step

   localparam int CsrAddrBits = 3;
   localparam int CsrDataBits = 16;

   localparam int ReqDataBits = 16;
   localparam int RspDataBits = 48;

   localparam logic [SpBits-1:0]     SpInitReset   = SpBits'(55);
   localparam logic [SpBits-1:0]     SpMinReset    = SpBits'(30);
   localparam logic [SpBits-1:0]     SpMaxReset    = SpBits'(90);
   localparam logic [StepBits-1:0]   SpStepReset   = StepBits'(1);
   localparam logic [HystBits-1:0]   HystReset     = HystBits'(30);
   localparam logic [PeriodBits-1:0] BtnPerReset   = PeriodBits'(50);
   localparam logic [PeriodBits-1:0] SmpPerReset   = PeriodBits'(2000);
   localparam logic [PeriodBits-1:0] DecPerReset   = PeriodBits'(1000);

   localparam logic signed [CalcBits-1:0] LowerSat = CalcBits'(1023);

   typedef enum logic [CsrAddrBits-1:0] {
      CSR_SP_INIT,
      CSR_SP_MIN,
      CSR_SP_MAX,
      CSR_SP_STEP,
      CSR_HYST,
      CSR_BTN_PERIOD,
      CSR_SMP_PERIOD,
      CSR_DEC_PERIOD
   } csr_index_type;

   typedef struct packed {
      logic [SpBits-1:0]  setpoint;
      logic [HumBits-1:0] humidity;
      logic               valid;
      logic               relay;
      logic [CntBits-1:0] poll_cnt;
      logic [CntBits-1:0] smp_cnt;
      logic [CntBits-1:0] dec_cnt;
   } ctrl_state_type;

   // Below minimum wins over above maximum when the limits are crossed.
   function automatic logic [SpBits-1:0] clamp_sp(
      input logic signed [SumBits-1:0] v,
      input logic [SpBits-1:0]         lo,
      input logic [SpBits-1:0]         hi
   );
      logic signed [SumBits-1:0] lo_s;
      logic signed [SumBits-1:0] hi_s;
      logic [SpBits-1:0]         res;
      lo_s = signed'(SumBits'(lo));
      hi_s = signed'(SumBits'(hi));
      if (v < lo_s) begin
         res = lo;
      end else if (v > hi_s) begin
         res = hi;
      end else begin
         res = v[SpBits-1:0];
      end
      return res;
   endfunction

   // Saturating increment of an elapsed counter.
   function automatic logic [CntBits-1:0] cnt_step(input logic [CntBits-1:0] cnt);
      logic [CntBits-1:0] res;
      res = (cnt != '1) ? cnt + CntBits'(1) : cnt;
      return res;
   endfunction

endpackage

// ===== rtl/hysteresis_humidity_controller.sv =====
`timescale 1ns / 1ps
// Humidity controller top: tick scheduler, setpoint buttons, sampler, relay.
// rsp_tvalid rises the cycle after accept; 1 item per cycle while rsp_tready is high.
// The rsp register frees in the cycle rsp_tready is high, so req_tready holds then.
// Reset (synchronous, active high) loads register defaults and the restart state;
// a restart item reloads the state from the current registers.
module hysteresis_humidity_controller
   import hhc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_we,
   input  logic [CsrAddrBits-1:0] csr_addr,
   input  logic [CsrDataBits-1:0] csr_wdata,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [0] up_edge, [1] down_edge, [2] reading_ok, [12:3] reading_tenths, rest zero
   input  logic [ReqDataBits-1:0] req_tdata,
   // [0] kind (0 tick, 1 restart)
   input  logic                   req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] relay_on, [7:1] setpoint_now, [17:8] humidity_held, [18] sensor_good,
   // [29:19] lower_bound, [40:30] upper_bound, rest zero
   output logic [RspDataBits-1:0] rsp_tdata
);

   // configuration registers
   logic [SpBits-1:0]     sp_init_ff;
   logic [SpBits-1:0]     sp_min_ff;
   logic [SpBits-1:0]     sp_max_ff;
   logic [StepBits-1:0]   sp_step_ff;
   logic [HystBits-1:0]   hyst_ff;
   logic [PeriodBits-1:0] btn_per_ff;
   logic [PeriodBits-1:0] smp_per_ff;
   logic [PeriodBits-1:0] dec_per_ff;

   ctrl_state_type        st_ff;
   ctrl_state_type        st_in;
   ctrl_state_type        restart_st;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RspDataBits-1:0] rsp_data_ff;
   logic [RspDataBits-1:0] rsp_data_in;

   logic                  accept;
   logic                  kind_restart;
   logic                  up_edge;
   logic                  down_edge;
   logic                  reading_ok;
   logic [HumBits-1:0]    reading_tenths;

   // per-item datapath
   logic [CntBits-1:0]    poll_inc;
   logic [CntBits-1:0]    smp_inc;
   logic [CntBits-1:0]    dec_inc;
   logic                  poll_fire;
   logic                  smp_fire;
   logic                  dec_fire;
   logic signed [SumBits-1:0]  sp_sum;
   logic signed [CalcBits-1:0] sp_x10;
   logic signed [CalcBits-1:0] lower;
   logic signed [CalcBits-1:0] upper;
   logic signed [CalcBits-1:0] hum_s;
   logic [BoundBits-1:0]  lower_out;

   assign kind_restart   = req_tuser;
   assign up_edge        = req_tdata[0];
   assign down_edge      = req_tdata[1];
   assign reading_ok     = req_tdata[2];
   assign reading_tenths = req_tdata[12:3];

   // Output register is the only buffer; take a new item when it is empty or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_init_ff <= SpInitReset;
         sp_min_ff  <= SpMinReset;
         sp_max_ff  <= SpMaxReset;
         sp_step_ff <= SpStepReset;
         hyst_ff    <= HystReset;
         btn_per_ff <= BtnPerReset;
         smp_per_ff <= SmpPerReset;
         dec_per_ff <= DecPerReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_SP_INIT:    sp_init_ff <= csr_wdata[SpBits-1:0];
            CSR_SP_MIN:     sp_min_ff  <= csr_wdata[SpBits-1:0];
            CSR_SP_MAX:     sp_max_ff  <= csr_wdata[SpBits-1:0];
            CSR_SP_STEP:    sp_step_ff <= csr_wdata[StepBits-1:0];
            CSR_HYST:       hyst_ff    <= csr_wdata[HystBits-1:0];
            CSR_BTN_PERIOD: btn_per_ff <= csr_wdata[PeriodBits-1:0];
            CSR_SMP_PERIOD: smp_per_ff <= csr_wdata[PeriodBits-1:0];
            CSR_DEC_PERIOD: dec_per_ff <= csr_wdata[PeriodBits-1:0];
         endcase
      end
   end

   // Restart state: clamped initial setpoint, flags clear, every task due on next tick.
   always_comb begin
      restart_st.setpoint = clamp_sp(signed'(SumBits'(sp_init_ff)), sp_min_ff, sp_max_ff);
      restart_st.humidity = '0;
      restart_st.valid    = 1'b0;
      restart_st.relay    = 1'b0;
      restart_st.poll_cnt = '1;
      restart_st.smp_cnt  = '1;
      restart_st.dec_cnt  = '1;
   end

   // Tick schedulers: count, then fire and clear once at or past the period.
   assign poll_inc  = cnt_step(st_ff.poll_cnt);
   assign smp_inc   = cnt_step(st_ff.smp_cnt);
   assign dec_inc   = cnt_step(st_ff.dec_cnt);
   assign poll_fire = CmpBits'(poll_inc) >= CmpBits'(btn_per_ff);
   assign smp_fire  = CmpBits'(smp_inc)  >= CmpBits'(smp_per_ff);
   assign dec_fire  = CmpBits'(dec_inc)  >= CmpBits'(dec_per_ff);

   // Both buttons: add then subtract, clamp the sum.
   always_comb begin
      sp_sum = signed'(SumBits'(st_ff.setpoint));
      if (up_edge) begin
         sp_sum = sp_sum + signed'(SumBits'(sp_step_ff));
      end
      if (down_edge) begin
         sp_sum = sp_sum - signed'(SumBits'(sp_step_ff));
      end
   end

   // Next state: restart reload, or a tick: poll, sample, then relay on new values.
   always_comb begin
      if (kind_restart) begin
         st_in = restart_st;
      end else begin
         st_in          = st_ff;
         st_in.poll_cnt = poll_fire ? '0 : poll_inc;
         st_in.smp_cnt  = smp_fire  ? '0 : smp_inc;
         st_in.dec_cnt  = dec_fire  ? '0 : dec_inc;
         if (poll_fire && (up_edge || down_edge)) begin
            st_in.setpoint = clamp_sp(sp_sum, sp_min_ff, sp_max_ff);
         end
         if (smp_fire) begin
            st_in.valid = reading_ok;
            if (reading_ok) begin
               st_in.humidity = reading_tenths;
            end
         end
      end
      // bounds follow the new setpoint (x10 as shift-add)
      sp_x10 = signed'(CalcBits'({st_in.setpoint, 3'b000}) + CalcBits'({st_in.setpoint, 1'b0}));
      lower  = sp_x10 - signed'(CalcBits'(hyst_ff));
      upper  = sp_x10 + signed'(CalcBits'(hyst_ff));
      hum_s  = signed'(CalcBits'(st_in.humidity));
      // relay holds while the sensor is invalid; dead band between lower and upper
      if (!kind_restart && dec_fire && st_in.valid) begin
         if (!st_ff.relay && (hum_s > upper)) begin
            st_in.relay = 1'b1;
         end else if (st_ff.relay && (hum_s < lower)) begin
            st_in.relay = 1'b0;
         end
      end
      lower_out = (lower > LowerSat) ? LowerSat[BoundBits-1:0] : lower[BoundBits-1:0];
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[0]     = st_in.relay;
      rsp_data_in[7:1]   = st_in.setpoint;
      rsp_data_in[17:8]  = st_in.humidity;
      rsp_data_in[18]    = st_in.valid;
      rsp_data_in[29:19] = lower_out;
      rsp_data_in[40:30] = upper[BoundBits-1:0];
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   // Controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.setpoint <= clamp_sp(signed'(SumBits'(SpInitReset)), SpMinReset, SpMaxReset);
         st_ff.humidity <= '0;
         st_ff.valid    <= 1'b0;
         st_ff.relay    <= 1'b0;
         st_ff.poll_cnt <= '1;
         st_ff.smp_cnt  <= '1;
         st_ff.dec_cnt  <= '1;
      end else if (accept) begin
         st_ff <= st_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
